>>> src/plctb_pkg.sv
// ============================================================================
// plctb_pkg: shared types and constants for the PLC timer bank
// Field widths, bank size, timer modes, controller states and the layout of
// one stored timer row.
// ============================================================================
package plctb_pkg;

    localparam int TIMER_COUNT = 64;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int NOW_W    = 32;
    localparam int PRESET_W = 16;
    localparam int BASE_W   = 10;
    localparam int ACC_W    = 16;

    // one quotient bit per divider step
    localparam int DIV_STEPS = NOW_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [MODE_W-1:0] {
        MODE_TON = 2'd0,
        MODE_TOF = 2'd1,
        MODE_TP  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               done;
        logic               running;
        logic [ACC_W-1:0]   acc;
        logic [NOW_W-1:0]   stamp;
    } timer_row_t;

endpackage

>>> src/plc_timer_bank.sv
// ============================================================================
// plc_timer_bank: bank of on-delay, off-delay and pulse timers
// Evaluates one timer per item against the millisecond clock and returns
// its done bit, running bit and accumulated count.
// ============================================================================
// An item runs through these steps from acceptance to its result: the timer's
// row is read from the state memory at the accepting edge, a prep step applies
// the mode's start and reset rules, a bit-serial restoring divider turns the
// elapsed milliseconds into time-base counts (one quotient bit per cycle), and
// a finish step applies the expiry rule, writes the row back and loads the
// result. A new item is taken on the cycle after the result is loaded, so the
// bank never takes a new item before it is through with the last one; a
// stalled result holds the bank in its last step. Each timer has a valid bit
// cleared by reset, so the state memory needs no clearing pass and an
// unwritten timer reads as all zero.
module plc_timer_bank (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [plctb_pkg::MODE_W-1:0]    req_type,
    input  logic [plctb_pkg::INDEX_W-1:0]   timer_index,
    input  logic                            enable,
    input  logic [plctb_pkg::NOW_W-1:0]     now_ms,
    input  logic [plctb_pkg::PRESET_W-1:0]  preset,
    input  logic [plctb_pkg::BASE_W-1:0]    time_base_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            done_flag,
    output logic                            running_flag,
    output logic [plctb_pkg::ACC_W-1:0]     accumulated
);
    import plctb_pkg::*;

    state_t state_reg, state_next;

    // item registers
    logic [MODE_W-1:0]   req_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic                en_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [PRESET_W-1:0] pre_reg;
    logic [BASE_W-1:0]   base_reg;
    logic                in_range_reg;

    // state memory
    timer_row_t             mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] row_valid_reg;
    timer_row_t             row_rd_reg;
    logic                   row_valid_rd_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;

    // working timer state
    logic               done_reg;
    logic               run_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [NOW_W-1:0]   stamp_reg;
    logic               timing_reg;

    // divider
    logic [NOW_W-1:0]   quo_reg;
    logic [BASE_W-1:0]  rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BASE_W:0]    rem_shift;
    logic [BASE_W:0]    rem_diff;
    logic               rem_ge;

    // output register
    logic               out_valid_reg;
    logic               done_out_reg;
    logic               run_out_reg;
    logic [ACC_W-1:0]   acc_out_reg;

    // rule results
    timer_row_t         row_cur;
    logic               done_next;
    logic               run_next;
    logic [ACC_W-1:0]   acc_next;
    logic [NOW_W-1:0]   stamp_next;
    logic               timing_next;
    logic               done_fin;
    logic               run_fin;
    logic [ACC_W-1:0]   acc_fin;
    logic               expired;
    logic               in_accept;
    logic               fin_go;

    assign in_accept = in_valid && !in_stall;
    assign fin_go    = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign rd_addr   = IDX_W'(timer_index);
    assign wr_addr   = IDX_W'(idx_reg);

    assign out_valid    = out_valid_reg;
    assign done_flag    = done_out_reg;
    assign running_flag = run_out_reg;
    assign accumulated  = acc_out_reg;

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // start and reset rules, applied before timing
    // ------------------------------------------------------------------
    always_comb
    begin
        row_cur     = row_valid_rd_reg ? row_rd_reg : '0;
        done_next   = row_cur.done;
        run_next    = row_cur.running;
        acc_next    = row_cur.acc;
        stamp_next  = row_cur.stamp;
        timing_next = 1'b0;
        case (req_reg)
            MODE_TON:
            begin
                if (!en_reg)
                begin
                    acc_next  = '0;
                    run_next  = 1'b0;
                    done_next = 1'b0;
                end
                if (en_reg && !done_next && !run_next)
                begin
                    run_next   = 1'b1;
                    stamp_next = now_reg;
                end
                timing_next = run_next;
            end
            MODE_TOF:
            begin
                if (en_reg && !done_next && !run_next)
                begin
                    done_next = 1'b1;
                end
                if (en_reg && run_next)
                begin
                    run_next = 1'b0;
                end
                if (!en_reg && done_next && !run_next)
                begin
                    run_next   = 1'b1;
                    stamp_next = now_reg;
                end
                timing_next = run_next;
            end
            MODE_TP:
            begin
                if (en_reg && !done_next && !run_next)
                begin
                    done_next  = 1'b1;
                    run_next   = 1'b1;
                    stamp_next = now_reg;
                end
                if (!en_reg && !done_next && run_next)
                begin
                    run_next = 1'b0;
                end
                timing_next = done_next;
            end
            default:
            begin
                // undefined mode: leave the timer as stored
            end
        endcase
    end

    // ------------------------------------------------------------------
    // divider step: shift in one dividend bit, subtract base if it fits
    // ------------------------------------------------------------------
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NOW_W-1]};
        rem_diff  = rem_shift - {1'b0, base_reg};
        rem_ge    = (rem_shift >= {1'b0, base_reg});
    end

    // ------------------------------------------------------------------
    // expiry rule; elapsed >= preset * base exactly when quotient >= preset
    // ------------------------------------------------------------------
    always_comb
    begin
        expired  = (quo_reg[NOW_W-1:PRESET_W] != '0) ||
                   (quo_reg[PRESET_W-1:0] >= pre_reg);
        done_fin = done_reg;
        run_fin  = run_reg;
        acc_fin  = acc_reg;
        if (timing_reg)
        begin
            acc_fin = quo_reg[ACC_W-1:0];
            if (expired)
            begin
                acc_fin = ACC_W'(pre_reg);
                case (req_reg)
                    MODE_TON:
                    begin
                        run_fin  = 1'b0;
                        done_fin = 1'b1;
                    end
                    MODE_TOF:
                    begin
                        run_fin  = 1'b0;
                        done_fin = 1'b0;
                    end
                    MODE_TP:
                    begin
                        done_fin = 1'b0;
                    end
                    default:
                    begin
                        done_fin = done_reg;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg      <= req_type;
            idx_reg      <= timer_index;
            en_reg       <= enable;
            now_reg      <= now_ms;
            pre_reg      <= preset;
            // treat a zero base as one
            base_reg     <= (time_base_ms == '0) ? BASE_W'(1) : time_base_ms;
            in_range_reg <= (32'(timer_index) < TIMER_COUNT);
        end
        if (state_reg == ST_PREP)
        begin
            done_reg   <= done_next;
            run_reg    <= run_next;
            acc_reg    <= acc_next;
            stamp_reg  <= stamp_next;
            timing_reg <= timing_next;
            quo_reg    <= now_reg - stamp_next;
            rem_reg    <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[NOW_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[BASE_W-1:0] : rem_shift[BASE_W-1:0];
        end
        if (fin_go)
        begin
            done_out_reg <= in_range_reg ? done_fin : 1'b0;
            run_out_reg  <= in_range_reg ? run_fin  : 1'b0;
            acc_out_reg  <= in_range_reg ? acc_fin  : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_PREP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fin_go && in_range_reg)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // state memory: read on acceptance, write back on finish
    always_ff @(posedge clk)
    begin
        row_rd_reg       <= mem[rd_addr];
        row_valid_rd_reg <= row_valid_reg[rd_addr];
        if (fin_go && in_range_reg)
        begin
            mem[wr_addr] <= '{done: done_fin, running: run_fin,
                              acc: acc_fin, stamp: stamp_reg};
        end
    end

`ifndef SYNTH
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_PREP)
        else $error("accepted item did not start rule evaluation");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < base_reg)
        else $error("divider remainder not below time base");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=>
        state_reg == ST_FINISH)
        else $error("divider did not finish after its last step");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid ##1 out_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish");

    a_out_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && !in_range_reg) |=>
        (!done_flag && !running_flag && accumulated == '0))
        else $error("out-of-bank timer gave a nonzero result");
`endif

endmodule
